>>> rtl/knnl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnl_pkg: shared types and constants of the nearest-neighbor link block
// Holds the item modes, the controller states, the command and status words
// passed between controller and datapath, the store depth and the fixed
// field widths.
// ----------------------------------------------------------------------------
package knnl_pkg;

    // Fixed field widths.
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = 9;
    localparam int DOUT_W      = 2 * COORD_BITS + 1;
    localparam int DLIST_W     = 34;
    localparam int NCOUNT_W    = 4;
    localparam int MODE_W      = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // Number of points the store holds; the index fields cover exactly this.
    localparam int POINT_DEPTH = 512;

    localparam logic [NCOUNT_W-1:0] NEIGHBOR_COUNT_RESET = 4'd3;
    localparam logic [PADDR_W-1:0]  ADDR_NEIGHBOR_COUNT  = 3'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic qread;
        logic qlatch;
        logic scan_issue;
        logic out_first;
        logic out_next;
    } dp_cmd_t;

    typedef struct packed {
        logic query_ok;
        logic scan_last;
        logic pipe_empty;
        logic out_last;
    } dp_sts_t;

endpackage

>>> rtl/knnl_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnl_dp: point store and distance datapath
// Point memory, scan counter, four-stage squared distance pipeline, a sorted
// best list with parallel insertion, and the output word registers.
// ----------------------------------------------------------------------------
module knnl_dp #(
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  knnl_pkg::dp_cmd_t                      cmd,
    output knnl_pkg::dp_sts_t                      sts,
    input  logic [knnl_pkg::COORD_BITS-1:0]        point_x,
    input  logic [knnl_pkg::COORD_BITS-1:0]        point_y,
    input  logic [knnl_pkg::IDX_W-1:0]             query_index,
    input  logic [knnl_pkg::NCOUNT_W-1:0]          neighbor_count,
    output logic [knnl_pkg::IDX_W-1:0]             neighbor_index,
    output logic [knnl_pkg::DOUT_W-1:0]            distance_sq,
    output logic                                   last
);
    import knnl_pkg::*;

    localparam int AW = $clog2(POINT_DEPTH);
    localparam int CW = $clog2(POINT_DEPTH + 1);
    localparam int LW = $clog2(MAX_NEIGHBORS + 1);
    localparam int KW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CB = COORD_BITS;

    // Point memory.
    logic [CB-1:0] x_mem [POINT_DEPTH];
    logic [CB-1:0] y_mem [POINT_DEPTH];
    logic [CB-1:0] x_rd_reg, y_rd_reg;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] count_reg;
    logic [AW-1:0] scan_reg;
    logic [AW-1:0] q_idx_reg;
    logic [CB-1:0] qx_reg, qy_reg;

    // Pipeline stages.
    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0] j1_reg, j2_reg, j3_reg, j4_reg;
    logic [CB-1:0] dx_reg, dy_reg;
    logic [2*CB-1:0] sx_reg, sy_reg;
    logic [DOUT_W-1:0] d_reg;

    // Sorted best list.
    logic [DLIST_W-1:0] dist_reg  [MAX_NEIGHBORS];
    logic [DLIST_W-1:0] dist_next [MAX_NEIGHBORS];
    logic [AW-1:0]      idx_reg   [MAX_NEIGHBORS];
    logic [AW-1:0]      idx_next  [MAX_NEIGHBORS];
    logic               lt        [MAX_NEIGHBORS];

    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_sel;
    logic [LW-1:0] limit;
    logic [LW-1:0] found;
    logic [IDX_W-1:0] nidx_reg;
    logic [DOUT_W-1:0] dsq_reg;
    logic              last_reg;

    assign rd_addr = cmd.qread ? AW'(query_index) : scan_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && (32'(count_reg) < POINT_DEPTH))
        begin
            x_mem[count_reg[AW-1:0]] <= point_x;
            y_mem[count_reg[AW-1:0]] <= point_y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    assign limit = (32'(neighbor_count) > MAX_NEIGHBORS) ? LW'(MAX_NEIGHBORS)
                                                         : LW'(neighbor_count);
    assign found = (32'(count_reg) <= 32'(limit)) ? LW'(count_reg - 1'b1) : limit;

    assign sts.query_ok   = (32'(query_index) < 32'(count_reg)) &&
                            (32'(count_reg) >= 2) && (limit != '0);
    assign sts.scan_last  = (32'(scan_reg) + 1 == 32'(count_reg));
    assign sts.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign sts.out_last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && (32'(count_reg) < POINT_DEPTH))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.qread)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            v1_reg <= cmd.scan_issue && (scan_reg != q_idx_reg);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.qread)
        begin
            q_idx_reg <= AW'(query_index);
        end
        if (cmd.qlatch)
        begin
            qx_reg <= x_rd_reg;
            qy_reg <= y_rd_reg;
        end
        j1_reg <= scan_reg;
        j2_reg <= j1_reg;
        j3_reg <= j2_reg;
        j4_reg <= j3_reg;
        dx_reg <= (x_rd_reg >= qx_reg) ? x_rd_reg - qx_reg : qx_reg - x_rd_reg;
        dy_reg <= (y_rd_reg >= qy_reg) ? y_rd_reg - qy_reg : qy_reg - y_rd_reg;
        sx_reg <= (2*CB)'(dx_reg) * (2*CB)'(dx_reg);
        sy_reg <= (2*CB)'(dy_reg) * (2*CB)'(dy_reg);
        d_reg  <= DOUT_W'(sx_reg) + DOUT_W'(sy_reg);
    end

    // Parallel insertion: the list stays sorted, so the slots that the new
    // distance beats form a tail; the first of them takes it and the rest
    // shift down by one. A strict compare keeps lower indices first on ties.
    always_comb
    begin
        for (int s = 0; s < MAX_NEIGHBORS; s++)
        begin
            lt[s] = ({1'b0, d_reg} < dist_reg[s]);
        end
        for (int s = 0; s < MAX_NEIGHBORS; s++)
        begin
            dist_next[s] = dist_reg[s];
            idx_next[s]  = idx_reg[s];
            if (lt[s])
            begin
                if (s == 0)
                begin
                    dist_next[s] = {1'b0, d_reg};
                    idx_next[s]  = j4_reg;
                end
                else if (!lt[(s == 0) ? 0 : s - 1])
                begin
                    dist_next[s] = {1'b0, d_reg};
                    idx_next[s]  = j4_reg;
                end
                else
                begin
                    dist_next[s] = dist_reg[(s == 0) ? 0 : s - 1];
                    idx_next[s]  = idx_reg[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < MAX_NEIGHBORS; s++)
        begin
            if (cmd.qread)
            begin
                dist_reg[s] <= '1;
                idx_reg[s]  <= '0;
            end
            else if (v4_reg)
            begin
                dist_reg[s] <= dist_next[s];
                idx_reg[s]  <= idx_next[s];
            end
        end
    end

    // Output words.
    assign k_sel = cmd.out_first ? '0 : k_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.out_first || cmd.out_next)
        begin
            k_reg    <= k_sel;
            last_reg <= (32'(k_sel) + 1 == 32'(found));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_first || cmd.out_next)
        begin
            nidx_reg <= IDX_W'(idx_reg[k_sel]);
            dsq_reg  <= dist_reg[k_sel][DOUT_W-1:0];
        end
    end

    assign neighbor_index = nidx_reg;
    assign distance_sq    = dsq_reg;
    assign last           = last_reg;

`ifndef ASSERT_OFF
    generate
        for (genvar g = 0; g + 1 < MAX_NEIGHBORS; g++)
        begin : g_sorted
            a_list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                $past(v4_reg) |-> dist_reg[g] <= dist_reg[g + 1])
                else $error("best list lost its order");
        end
    endgenerate

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= POINT_DEPTH)
        else $error("point count beyond store depth");

    a_skip_query: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> j1_reg != q_idx_reg)
        else $error("queried point entered the distance pipeline");
`endif

endmodule

>>> rtl/knnl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knnl_ctrl: sequencer of the nearest-neighbor link block
// Takes input words, runs the store scan of a query and hands out the
// result words one at a time.
// ----------------------------------------------------------------------------
module knnl_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [knnl_pkg::MODE_W-1:0]     mode,
    output logic                            out_valid,
    input  logic                            out_stall,
    output knnl_pkg::dp_cmd_t               cmd,
    input  knnl_pkg::dp_sts_t               sts
);
    import knnl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_CLEAR:  cmd.clear  = 1'b1;
                        MODE_APPEND: cmd.append = 1'b1;
                        MODE_QUERY:
                        begin
                            if (sts.query_ok)
                            begin
                                cmd.qread  = 1'b1;
                                state_next = ST_QREAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_QREAD:
            begin
                cmd.qlatch = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    cmd.out_first = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (sts.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && mode == MODE_QUERY && sts.query_ok)
        |=> state_reg == ST_QREAD)
        else $error("valid query did not start a scan");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> sts.pipe_empty)
        else $error("results sent while distances still in flight");

    a_more_words: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !sts.out_last) |=> out_valid)
        else $error("query ended before its final word");
`endif

endmodule

>>> rtl/k_nearest_neighbor_links_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_neighbor_links_core: brute-force 2D nearest-neighbor search
// Stores points in unsigned 12.4 and reports, per query, the nearest other
// stored points by squared distance, nearest first, lower index on ties.
// ----------------------------------------------------------------------------
// Clear and append words are taken without stalling the input; the next
// word is taken the cycle after.
// Before its first result word, a query makes one read of the queried
// point, one store read per stored point through the single read port
// of the point memory, and passes four distance pipeline stages.
// Result words then follow one per cycle while out_stall stays low.
// Reset (rst_n low, asynchronous) empties the store and sets neighbor_count
// to 3; the point memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_links_core #(
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [knnl_pkg::PADDR_W-1:0]           paddr,
    input  logic [knnl_pkg::PDATA_W-1:0]           pwdata,
    output logic [knnl_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready,
    // Input words.
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [knnl_pkg::MODE_W-1:0]            mode,
    input  logic [knnl_pkg::COORD_BITS-1:0]        point_x,
    input  logic [knnl_pkg::COORD_BITS-1:0]        point_y,
    input  logic [knnl_pkg::IDX_W-1:0]             query_index,
    // Result words.
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [knnl_pkg::IDX_W-1:0]             neighbor_index,
    output logic [knnl_pkg::DOUT_W-1:0]            distance_sq,
    output logic                                   last
);
    import knnl_pkg::*;

    logic [NCOUNT_W-1:0] ncount_reg;
    logic                cfg_write;
    logic                cfg_hit;
    dp_cmd_t             cmd;
    dp_sts_t             sts;

    // The register file is a single word at byte address zero. The low two
    // address bits are ignored; anything at a higher word address reads as
    // zero and ignores writes.
    assign pready    = 1'b1;
    assign cfg_hit   = ({paddr[PADDR_W-1:2], 2'b00} == ADDR_NEIGHBOR_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;
    assign prdata    = cfg_hit ? PDATA_W'(ncount_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg <= NEIGHBOR_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            ncount_reg <= pwdata[NCOUNT_W-1:0];
        end
    end

    // The controller sequences the words; the datapath holds the store, the
    // distance pipeline, the sorted best list and the result registers.
    knnl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    knnl_dp #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .point_x        (point_x),
        .point_y        (point_y),
        .query_index    (query_index),
        .neighbor_count (ncount_reg),
        .neighbor_index (neighbor_index),
        .distance_sq    (distance_sq),
        .last           (last)
    );

endmodule

>>> sim/k_nearest_neighbor_links_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_neighbor_links_core_test: self-checking bench of the 2D k-NN core
// Drives clear, append and query words with random gaps, keeps its own copy
// of the point store to work out the nearest neighbors of every query, and
// checks each result word in order while the result side stalls at random.
// ----------------------------------------------------------------------------
module k_nearest_neighbor_links_core_test;
    import knnl_pkg::*;

    // Depths of the store and of the neighbor list, as built into the core.
    localparam int STORE_DEPTH   = 512;
    localparam int LIST_DEPTH    = 8;
    // Percentage of cycles on which either side holds back.
    localparam int IDLE_PERCENT  = 29;
    // Cycles to let pass once the last expected word is in, so that the
    // core is surely idle before the configuration changes.
    localparam int SETTLE_CYCLES = 600;
    // Target number of random clear, append and query words.
    localparam int RANDOM_WORDS  = 170;
    // Points appended in one long stretch without any idling.
    localparam int FILL_POINTS   = 120;
    // Mode code that the core must ignore.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Cap on printed result-word mismatch lines; all mismatches are still counted.
    localparam int MAX_REPORTS   = 30;

    typedef struct {
        logic [MODE_W-1:0]     mode;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [IDX_W-1:0]      index;
    } input_word_t;

    typedef struct {
        logic [IDX_W-1:0]  index;
        logic [DOUT_W-1:0] distance;
        logic              last;
    } neighbor_result_t;

    // Clock and reset.
    logic clk = 1'b0;
    logic rst_n;

    // Configuration port.
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Input side. These are driven only by the driver block below.
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [MODE_W-1:0]     mode        = '0;
    logic [COORD_BITS-1:0] point_x     = '0;
    logic [COORD_BITS-1:0] point_y     = '0;
    logic [IDX_W-1:0]      query_index = '0;

    // Result side. out_stall is driven only by the monitor block.
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [IDX_W-1:0]      neighbor_index;
    logic [DOUT_W-1:0]     distance_sq;
    logic                  last;

    // Words waiting to be driven, and neighbor results waiting to arrive.
    input_word_t      pending_words[$];
    neighbor_result_t expected_neighbors[$];
    input_word_t      presented_word;
    neighbor_result_t oldest_neighbor;

    // Our own copy of the point store and of the neighbor_count register.
    logic [COORD_BITS-1:0] shadow_x [STORE_DEPTH];
    logic [COORD_BITS-1:0] shadow_y [STORE_DEPTH];
    int unsigned           shadow_count;
    logic [NCOUNT_W-1:0]   shadow_neighbor_count;

    // When set, neither side idles or stalls.
    logic no_idle = 1'b0;

    int errors           = 0;
    int words_taken      = 0;
    int results_checked  = 0;
    int queries_answered = 0;
    int settings_written = 0;

    k_nearest_neighbor_links_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .point_x        (point_x),
        .point_y        (point_y),
        .query_index    (query_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .neighbor_index (neighbor_index),
        .distance_sq    (distance_sq),
        .last           (last)
    );

    always #5 clk = ~clk;

    // Apply one accepted word to the shadow store. A query brute-forces the
    // squared distance to every other stored point and keeps a list sorted
    // by distance; a strict compare keeps the lower index ahead on ties,
    // because candidates are visited in ascending index order.
    task automatic apply_word(input input_word_t w);
        logic [IDX_W-1:0]      best_idx  [LIST_DEPTH];
        logic [DLIST_W-1:0]    best_dist [LIST_DEPTH];
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [DLIST_W-1:0]    wide_dx;
        logic [DLIST_W-1:0]    wide_dy;
        logic [DLIST_W-1:0]    d;
        int unsigned           q;
        int unsigned           limit;
        int unsigned           found;
        int unsigned           pos;
        int unsigned           j;
        int unsigned           s;
        int unsigned           k;
        neighbor_result_t      r;

        case (w.mode)
            MODE_CLEAR: shadow_count = 0;
            MODE_APPEND:
            begin
                // A full store silently drops the point.
                if (shadow_count < STORE_DEPTH)
                begin
                    shadow_x[shadow_count] = w.x;
                    shadow_y[shadow_count] = w.y;
                    shadow_count++;
                end
            end
            MODE_QUERY:
            begin
                q = w.index;
                // Register values above the list depth saturate.
                limit = (shadow_neighbor_count > LIST_DEPTH) ? LIST_DEPTH
                                                             : shadow_neighbor_count;
                if (q < shadow_count && limit != 0)
                begin
                    for (k = 0; k < LIST_DEPTH; k++)
                    begin
                        best_idx[k]  = '0;
                        best_dist[k] = '1;
                    end
                    for (j = 0; j < shadow_count; j++)
                    begin
                        if (j != q)
                        begin
                            dx = (shadow_x[q] >= shadow_x[j]) ? shadow_x[q] - shadow_x[j]
                                                              : shadow_x[j] - shadow_x[q];
                            dy = (shadow_y[q] >= shadow_y[j]) ? shadow_y[q] - shadow_y[j]
                                                              : shadow_y[j] - shadow_y[q];
                            wide_dx = DLIST_W'(dx);
                            wide_dy = DLIST_W'(dy);
                            d = wide_dx * wide_dx + wide_dy * wide_dy;
                            pos = limit;
                            while (pos > 0 && d < best_dist[pos-1])
                                pos--;
                            if (pos < limit)
                            begin
                                for (s = limit - 1; s > pos; s--)
                                begin
                                    best_dist[s] = best_dist[s-1];
                                    best_idx[s]  = best_idx[s-1];
                                end
                                best_dist[pos] = d;
                                best_idx[pos]  = IDX_W'(j);
                            end
                        end
                    end
                    // A lone point has no neighbors at all.
                    found = shadow_count - 1;
                    if (found > limit)
                        found = limit;
                    if (found != 0)
                        queries_answered++;
                    for (k = 0; k < found; k++)
                    begin
                        r.index    = best_idx[k];
                        r.distance = best_dist[k][DOUT_W-1:0];
                        r.last     = (k + 1 == found);
                        expected_neighbors.insert(expected_neighbors.size(), r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Driver: at each rising edge, account for a word taken at this edge
    // and then either offer the next pending word or idle. A new word is
    // only put out once the previous one has been taken, so the payload
    // stays put while the core stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                apply_word(presented_word);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    presented_word = pending_words.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= presented_word.mode;
                    point_x     <= presented_word.x;
                    point_y     <= presented_word.y;
                    query_index <= presented_word.index;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted result word with the oldest one
    // predicted, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (expected_neighbors.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result word with none expected: index %0d dist %0d last %0b",
                                 $time, neighbor_index, distance_sq, last);
                end
                else
                begin
                    oldest_neighbor = expected_neighbors.pop_front();
                    if (neighbor_index !== oldest_neighbor.index)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: neighbor_index expected %0d actual %0d",
                                     $time, oldest_neighbor.index, neighbor_index);
                    end
                    if (distance_sq !== oldest_neighbor.distance)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: distance_sq expected %0d actual %0d",
                                     $time, oldest_neighbor.distance, distance_sq);
                    end
                    if (last !== oldest_neighbor.last)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: last expected %0b actual %0b",
                                     $time, oldest_neighbor.last, last);
                    end
                end
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    task automatic push_word(input logic [MODE_W-1:0] m, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y, input logic [IDX_W-1:0] qi);
        input_word_t w;
        w.mode  = m;
        w.x     = x;
        w.y     = y;
        w.index = qi;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Wait until every word has been taken and every result has come back,
    // then let the core settle before anything else changes.
    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_neighbors.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write neighbor_count while the core is idle, then read it back. The
    // read setup follows the write access directly, so psel stays high.
    task automatic write_neighbor_count(input logic [NCOUNT_W-1:0] value);
        drain_and_settle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NEIGHBOR_COUNT;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        // The register takes the value at this edge.
        @(posedge clk);
        shadow_neighbor_count = value;
        settings_written++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[NCOUNT_W-1:0] !== value)
        begin
            errors++;
            $display("%0t: neighbor_count read back expected %0d actual %0d",
                     $time, value, prdata[NCOUNT_W-1:0]);
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // One well-formed random sequence: clear, a handful of appends and a
    // few queries, with the odd ignored word mixed in. Returns the number
    // of clear, append and query words in it.
    task automatic push_random_set(output int acted);
        int                    n;
        int                    k;
        int                    style;
        int                    queries;
        logic [COORD_BITS-1:0] base_x;
        logic [COORD_BITS-1:0] base_y;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;

        acted = 0;
        push_word(MODE_CLEAR, $urandom(), $urandom(), $urandom());
        acted++;
        k = $urandom_range(0, 9);
        n = (k == 0) ? 1 : (k == 1) ? $urandom_range(17, 40) : $urandom_range(2, 16);
        style  = $urandom_range(0, 2);
        base_x = $urandom_range(0, 65000);
        base_y = $urandom_range(0, 65000);
        for (k = 0; k < n; k++)
        begin
            case (style)
                // Points on a coarse grid: equal distances and duplicates.
                0:
                begin
                    x = base_x + COORD_BITS'(16 * $urandom_range(0, 3));
                    y = base_y + COORD_BITS'(16 * $urandom_range(0, 3));
                end
                // Corners and edges of the coordinate range.
                1:
                begin
                    x = ($urandom_range(0, 2) == 0) ? $urandom() :
                        ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    y = ($urandom_range(0, 2) == 0) ? $urandom() :
                        ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                end
                default:
                begin
                    x = $urandom();
                    y = $urandom();
                end
            endcase
            push_word(MODE_APPEND, x, y, $urandom());
            acted++;
            if ($urandom_range(0, 9) == 0)
                push_word(MODE_UNUSED, $urandom(), $urandom(), $urandom());
        end
        queries = $urandom_range(2, 6);
        for (k = 0; k < queries; k++)
        begin
            if ($urandom_range(0, 99) < 85)
                push_word(MODE_QUERY, $urandom(), $urandom(), $urandom_range(0, n - 1));
            else
                push_word(MODE_QUERY, $urandom(), $urandom(), $urandom());
            acted++;
        end
    endtask

    initial
    begin
        int          k;
        int          set_no;
        int          acted;
        int          random_total;
        logic [NCOUNT_W-1:0] next_count;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        shadow_count          = 0;
        shadow_neighbor_count = NEIGHBOR_COUNT_RESET;
        for (k = 0; k < STORE_DEPTH; k++)
        begin
            shadow_x[k] = '0;
            shadow_y[k] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first with the reset neighbor count. A query on
        // an empty store, an ignored mode, and a lone point all give nothing.
        push_word(MODE_QUERY, 16'hFFFF, 16'hFFFF, '0);
        push_word(MODE_UNUSED, 16'hFFFF, 16'hFFFF, '1);
        push_word(MODE_APPEND, 16'h0000, 16'h0000, '1);
        push_word(MODE_QUERY, 16'h0000, 16'h0000, '0);
        // The four corners plus a duplicate of the origin: largest possible
        // distance, a zero distance, and ties broken by index.
        push_word(MODE_APPEND, 16'hFFFF, 16'hFFFF, '0);
        push_word(MODE_APPEND, 16'hFFFF, 16'h0000, '0);
        push_word(MODE_APPEND, 16'h0000, 16'hFFFF, '1);
        push_word(MODE_APPEND, 16'h0000, 16'h0000, '0);
        for (k = 0; k < 5; k++)
            push_word(MODE_QUERY, $urandom(), $urandom(), IDX_W'(k));
        // Indexes at and well past the count.
        push_word(MODE_QUERY, '0, '0, 9'd5);
        push_word(MODE_QUERY, '1, '1, 9'd511);

        // Full list depth, then zero, then a value that saturates, then one.
        write_neighbor_count(4'd8);
        push_word(MODE_QUERY, '0, '0, 9'd1);
        push_word(MODE_QUERY, '0, '0, 9'd4);
        write_neighbor_count(4'd0);
        push_word(MODE_QUERY, '0, '0, 9'd2);
        write_neighbor_count(4'd15);
        push_word(MODE_QUERY, '0, '0, 9'd3);
        write_neighbor_count(4'd1);
        push_word(MODE_QUERY, '0, '0, 9'd0);
        // After a clear nothing is left to query.
        push_word(MODE_CLEAR, '1, '1, '1);
        push_word(MODE_QUERY, '0, '0, 9'd0);

        // Append a long run of points without any idling, query the last,
        // first and a middle entry, and one index far past the count.
        write_neighbor_count(4'd8);
        no_idle = 1'b1;
        for (k = 0; k < FILL_POINTS; k++)
            push_word(MODE_APPEND, $urandom(), $urandom(), $urandom());
        push_word(MODE_QUERY, $urandom(), $urandom(), IDX_W'(FILL_POINTS - 1));
        push_word(MODE_QUERY, $urandom(), $urandom(), 9'd0);
        push_word(MODE_QUERY, $urandom(), $urandom(), IDX_W'(FILL_POINTS / 2));
        push_word(MODE_QUERY, $urandom(), $urandom(), 9'd300);
        drain_and_settle();
        no_idle = 1'b0;
        write_neighbor_count(4'd2);
        push_word(MODE_QUERY, $urandom(), $urandom(), $urandom());

        // Random part: one random neighbor count per few sets, with one run
        // of sets in which neither side ever idles.
        random_total = 0;
        set_no       = 0;
        while (random_total < RANDOM_WORDS)
        begin
            if (set_no % 4 == 3)
            begin
                k = $urandom_range(0, 9);
                next_count = (k == 0) ? 4'd0 :
                             (k == 1) ? NCOUNT_W'($urandom_range(9, 15)) :
                             NCOUNT_W'($urandom_range(1, 8));
                write_neighbor_count(next_count);
            end
            no_idle = (set_no >= 4 && set_no < 8);
            push_random_set(acted);
            random_total += acted;
            set_no++;
        end

        drain_and_settle();
        $display("Ran %0d input words and checked %0d result words from %0d answered queries,",
                 words_taken, results_checked, queries_answered);
        $display("across %0d neighbor_count writes, a long unbroken fill and random idling.",
                 settings_written);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/knnl_pkg.sv
rtl/knnl_dp.sv
rtl/knnl_ctrl.sv
rtl/k_nearest_neighbor_links_core.sv
sim/k_nearest_neighbor_links_core_test.sv
